/* rtl/core/assert_macros.svh */
// assertion macros used by the checker file of the tilt block
// depends on nothing; guarded against double inclusion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while rst is high
`define ATRP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("atrp: same-cycle check failed");

// next-cycle implication, disabled while rst is high
`define ATRP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("atrp: next-cycle check failed");

`endif

/* rtl/core/atrp_pkg.sv */
// types, constants and arithmetic helpers of the accelerometer tilt block
// used by atrp_front, atrp_back and the top level
package atrp_pkg;

   localparam int SAMPLE_BITS_DEF  = 16;
   localparam int CORDIC_STEPS_DEF = 16;

   localparam int IN_W      = 16;
   localparam int GAIN_W    = 24;
   localparam int ANG_W     = 17;
   localparam int NORM_BITS = 30;
   localparam int RT_W      = 62;
   localparam int ROOT_ITERS = 31;
   localparam int ROOT_CNT_W = 5;
   localparam int ATAN_W    = 23;
   localparam int ATAN_IDX_W = 5;
   localparam int Z_W       = 26;
   localparam int CX_W      = 36;
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 40;

   localparam logic [GAIN_W-1:0] X_GAIN_RST = 24'd63148;
   localparam logic [GAIN_W-1:0] Y_GAIN_RST = 24'd63084;
   localparam logic [GAIN_W-1:0] Z_GAIN_RST = 24'd58597;

   localparam logic signed [ANG_W-1:0] ANG_MAX  = 17'sd46080;
   localparam logic signed [ANG_W:0]   ANG_HI   = 18'sd46080;
   localparam logic signed [ANG_W:0]   ANG_LO   = -18'sd46080;
   localparam logic signed [Z_W-1:0]   RIGHT_Q16 = 26'sd5898240;
   localparam logic [Z_W-1:0]          HALF_LSB  = 26'd128;

   // register indexes of the configuration port
   localparam logic [1:0] CSR_X_GAIN = 2'd0;
   localparam logic [1:0] CSR_Y_GAIN = 2'd1;
   localparam logic [1:0] CSR_Z_GAIN = 2'd2;

   typedef enum logic [1:0] {
      ACT_MEASURE = 2'd0,
      ACT_ZERO    = 2'd1,
      ACT_LOAD    = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef struct packed {
      action_type               action;
      logic [IN_W-1:0]          x_sample;
      logic [IN_W-1:0]          y_sample;
      logic [IN_W-1:0]          z_sample;
      logic signed [ANG_W-1:0]  roll_load;
      logic signed [ANG_W-1:0]  pitch_load;
   } item_type;

   typedef struct packed {
      logic [RT_W-1:0] n;
      logic [RT_W-1:0] r;
   } root_type;

   typedef struct packed {
      logic signed [CX_W-1:0] x;
      logic signed [CX_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } cord_type;

   // atan(2^-i) in 2^-16 degree
   function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
      logic [ATAN_W-1:0] v;
      case (idx)
         5'd0:    v = 23'd2949120;
         5'd1:    v = 23'd1740967;
         5'd2:    v = 23'd919879;
         5'd3:    v = 23'd466945;
         5'd4:    v = 23'd234379;
         5'd5:    v = 23'd117304;
         5'd6:    v = 23'd58666;
         5'd7:    v = 23'd29335;
         5'd8:    v = 23'd14668;
         5'd9:    v = 23'd7334;
         5'd10:   v = 23'd3667;
         5'd11:   v = 23'd1833;
         5'd12:   v = 23'd917;
         5'd13:   v = 23'd458;
         5'd14:   v = 23'd229;
         5'd15:   v = 23'd115;
         5'd16:   v = 23'd57;
         5'd17:   v = 23'd29;
         5'd18:   v = 23'd14;
         5'd19:   v = 23'd7;
         5'd20:   v = 23'd4;
         5'd21:   v = 23'd2;
         5'd22:   v = 23'd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   // one digit of the bit-by-bit integer square root
   function automatic root_type root_step(input logic [RT_W-1:0] n,
                                          input logic [RT_W-1:0] r,
                                          input logic [RT_W-1:0] b);
      logic [RT_W:0] trial;
      root_type      res;
      trial = {1'b0, r} + {1'b0, b};
      if ({1'b0, n} >= trial) begin
         res.n = n - trial[RT_W-1:0];
         res.r = (r >> 1) + b;
      end else begin
         res.n = n;
         res.r = r >> 1;
      end
      return res;
   endfunction

   // one vectoring rotation
   function automatic cord_type cordic_step(input cord_type c,
                                            input logic [ATAN_IDX_W-1:0] i);
      logic signed [CX_W-1:0] dx;
      logic signed [CX_W-1:0] dy;
      logic signed [Z_W-1:0]  da;
      cord_type               res;
      dx = c.y >>> i;
      dy = c.x >>> i;
      da = $signed(Z_W'(atan_q16(i)));
      if (!c.y[CX_W-1]) begin
         res.x = c.x + dx;
         res.y = c.y - dy;
         res.z = c.z + da;
      end else begin
         res.x = c.x - dx;
         res.y = c.y + dy;
         res.z = c.z - da;
      end
      return res;
   endfunction

   // clamp to [0, 90] degrees, round to 1/256 degree, force zero when nz is low, apply sign
   function automatic logic signed [ANG_W-1:0] fin_angle(input logic nz, input logic neg,
                                                        input logic signed [Z_W-1:0] z);
      logic [Z_W-1:0]          zc;
      logic [Z_W-1:0]          rs;
      logic signed [ANG_W-1:0] a;
      if (z < 0) begin
         zc = '0;
      end else if (z > RIGHT_Q16) begin
         zc = RIGHT_Q16;
      end else begin
         zc = z;
      end
      rs = zc + HALF_LSB;
      a  = $signed({2'b00, rs[22:8]});
      if (!nz) begin
         a = '0;
      end
      if (neg) begin
         a = -a;
      end
      return a;
   endfunction

   function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [ANG_W:0] v);
      logic signed [ANG_W-1:0] res;
      if (v > ANG_HI) begin
         res = ANG_MAX;
      end else if (v < ANG_LO) begin
         res = -ANG_MAX;
      end else begin
         res = v[ANG_W-1:0];
      end
      return res;
   endfunction

endpackage

/* rtl/core/accel_tilt_roll_pitch.sv */
// Accelerometer tilt unit: each request beat gives one response beat with
// roll and pitch in 1/256 degree relative to stored bases; a zero beat gives
// the absolute angles and stores them as the new bases. An item is taken
// from the queue, scaled in the shared gain multiplier (measure beats only),
// normalized one bit a cycle, squared in the squaring multiplier, then goes
// through the bit-serial square root, the CORDIC_STEPS cordic steps (16 by
// default), setup and output, plus any wait for the response slot; an
// all-zero vector skips normalizing, root and cordic. A two-entry queue
// takes new beats while the engine works; gain writes are taken in any cycle.
// top level; instantiates atrp_front and atrp_back, uses atrp_pkg
module accel_tilt_roll_pitch #(
   parameter int SAMPLE_BITS  = atrp_pkg::SAMPLE_BITS_DEF,
   parameter int CORDIC_STEPS = atrp_pkg::CORDIC_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // x_sample, y_sample, z_sample, roll_load, pitch_load, zero fill
   input  logic [atrp_pkg::REQ_DATA_W-1:0]   req_tdata,
   // action
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // roll_deg, pitch_deg, zero fill
   output logic [atrp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [atrp_pkg::GAIN_W-1:0]       csr_wdata
);
   import atrp_pkg::*;

   item_type                q_item;
   logic                    q_valid;
   logic                    q_pop;
   logic signed [ANG_W-1:0] rsp_roll, rsp_pitch;

   // gain registers accept every beat
   assign csr_ready = 1'b1;

   atrp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_item     (q_item),
      .q_valid    (q_valid),
      .q_pop      (q_pop)
   );

   atrp_back #(
      .SAMPLE_BITS  (SAMPLE_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_item     (q_item),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_roll   (rsp_roll),
      .rsp_pitch  (rsp_pitch)
   );

   // pack the response beat
   assign rsp_tdata = {{(RSP_DATA_W - 2*ANG_W){1'b0}}, rsp_pitch, rsp_roll};

endmodule

/* rtl/core/atrp_front.sv */
// front of the tilt block: takes request beats, decodes the action and
// holds up to two items in a queue for the back end; uses atrp_pkg
module atrp_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // x_sample, y_sample, z_sample, roll_load, pitch_load, zero fill
   input  logic [atrp_pkg::REQ_DATA_W-1:0]   req_tdata,
   // action
   input  logic [1:0]                        req_tuser,
   output atrp_pkg::item_type                q_item,
   output logic                              q_valid,
   input  logic                              q_pop
);
   import atrp_pkg::*;

   item_type    q_ff [2];
   item_type    new_item;
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, pop;

   // decode the beat into an item
   always_comb begin
      new_item.action     = action_type'(req_tuser);
      new_item.x_sample   = req_tdata[15:0];
      new_item.y_sample   = req_tdata[31:16];
      new_item.z_sample   = req_tdata[47:32];
      new_item.roll_load  = $signed(req_tdata[64:48]);
      new_item.pitch_load = $signed(req_tdata[81:65]);
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (cnt_ff != 2'd0);
   assign pop        = q_pop && q_valid;
   assign q_item     = q_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

/* rtl/core/atrp_back.sv */
// back end of the tilt block: gain scaling, normalizing, square roots,
// two cordic lanes and base handling, plus the gain registers; uses atrp_pkg
module atrp_back #(
   parameter int SAMPLE_BITS  = atrp_pkg::SAMPLE_BITS_DEF,
   parameter int CORDIC_STEPS = atrp_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  atrp_pkg::item_type                  q_item,
   input  logic                                q_valid,
   output logic                                q_pop,
   input  logic                                csr_valid,
   input  logic [1:0]                          csr_index,
   input  logic [atrp_pkg::GAIN_W-1:0]         csr_wdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic signed [atrp_pkg::ANG_W-1:0]   rsp_roll,
   output logic signed [atrp_pkg::ANG_W-1:0]   rsp_pitch
);
   import atrp_pkg::*;

   localparam int SCL_W = SAMPLE_BITS + GAIN_W;
   localparam int CNT_W = $clog2(CORDIC_STEPS);
   localparam int SQ_W  = 2 * NORM_BITS;
   localparam int ROOT_TOP = 2 * (ROOT_ITERS - 1);

   typedef enum logic [9:0] {
      S_IDLE = 10'b00_0000_0001,
      S_MUL  = 10'b00_0000_0010,
      S_PREP = 10'b00_0000_0100,
      S_NORM = 10'b00_0000_1000,
      S_SQR  = 10'b00_0001_0000,
      S_SUM  = 10'b00_0010_0000,
      S_ROOT = 10'b00_0100_0000,
      S_CORD = 10'b00_1000_0000,
      S_FIN  = 10'b01_0000_0000,
      S_OUT  = 10'b10_0000_0000
   } state_type;

   state_type                state_ff, state_in;
   item_type                 item_ff;
   logic [GAIN_W-1:0]        x_gain_ff, y_gain_ff, z_gain_ff;
   logic signed [SCL_W-1:0]  scl_x_ff, scl_y_ff, scl_z_ff;
   logic signed [ANG_W-1:0]  roll_base_ff, pitch_base_ff;
   logic [1:0]               ax_ff;
   logic [SCL_W-1:0]         mx_ff, my_ff, mz_ff;
   logic [SCL_W-1:0]         mag_x, mag_y, mag_z, mag_or;
   logic [SQ_W-1:0]          sq_x_ff, sq_y_ff, sq_z_ff;
   logic [RT_W-1:0]          bit_ff;
   logic [ROOT_CNT_W-1:0]    rcnt_ff;
   root_type                 rt_p_ff, rt_r_ff, rt_p_in, rt_r_in;
   cord_type                 cd_p_ff, cd_r_ff, cd_p_in, cd_r_in;
   logic [CNT_W-1:0]         ccnt_ff;
   logic signed [ANG_W-1:0]  ang_p_ff, ang_r_ff;
   logic                     rsp_valid_ff;
   logic signed [ANG_W-1:0]  rsp_roll_ff, rsp_pitch_ff;
   logic signed [SAMPLE_BITS-1:0] mul_smp;
   logic [GAIN_W-1:0]        mul_gain;
   logic signed [SCL_W:0]    mul_full;
   logic [NORM_BITS-1:0]     sq_op;
   logic [SQ_W-1:0]          sq_full;
   logic                     out_free;
   logic signed [ANG_W:0]    diff_r, diff_p;

   assign q_pop      = (state_ff == S_IDLE) && q_valid;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_roll   = rsp_roll_ff;
   assign rsp_pitch  = rsp_pitch_ff;

   // shared scaling and squaring multipliers, one axis a cycle
   always_comb begin
      case (ax_ff)
         2'd0: begin
            mul_smp  = $signed(item_ff.x_sample[SAMPLE_BITS-1:0]);
            mul_gain = x_gain_ff;
            sq_op    = mx_ff[NORM_BITS-1:0];
         end
         2'd1: begin
            mul_smp  = $signed(item_ff.y_sample[SAMPLE_BITS-1:0]);
            mul_gain = y_gain_ff;
            sq_op    = my_ff[NORM_BITS-1:0];
         end
         default: begin
            mul_smp  = $signed(item_ff.z_sample[SAMPLE_BITS-1:0]);
            mul_gain = z_gain_ff;
            sq_op    = mz_ff[NORM_BITS-1:0];
         end
      endcase
      mul_full = mul_smp * $signed({1'b0, mul_gain});
      sq_full  = sq_op * sq_op;
   end

   // magnitudes of the kept vector
   always_comb begin
      mag_x  = scl_x_ff[SCL_W-1] ? SCL_W'(-scl_x_ff) : SCL_W'(scl_x_ff);
      mag_y  = scl_y_ff[SCL_W-1] ? SCL_W'(-scl_y_ff) : SCL_W'(scl_y_ff);
      mag_z  = scl_z_ff[SCL_W-1] ? SCL_W'(-scl_z_ff) : SCL_W'(scl_z_ff);
      mag_or = mx_ff | my_ff | mz_ff;
   end

   // root and cordic lanes
   always_comb begin
      rt_p_in = root_step(rt_p_ff.n, rt_p_ff.r, bit_ff);
      rt_r_in = root_step(rt_r_ff.n, rt_r_ff.r, bit_ff);
      cd_p_in = cordic_step(cd_p_ff, ATAN_IDX_W'(ccnt_ff));
      cd_r_in = cordic_step(cd_r_ff, ATAN_IDX_W'(ccnt_ff));
   end

   // output values against the bases
   always_comb begin
      diff_r = (ANG_W+1)'(ang_r_ff) - (ANG_W+1)'(roll_base_ff);
      diff_p = (ANG_W+1)'(ang_p_ff) - (ANG_W+1)'(pitch_base_ff);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               state_in = (q_item.action == ACT_MEASURE) ? S_MUL : S_PREP;
            end
         end
         S_MUL: begin
            if (ax_ff == 2'd2) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            if ((scl_x_ff == '0) && (scl_y_ff == '0) && (scl_z_ff == '0)) begin
               state_in = S_FIN;
            end else begin
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            if (!(|mag_or[SCL_W-1:NORM_BITS]) && mag_or[NORM_BITS-1]) begin
               state_in = S_SQR;
            end
         end
         S_SQR: begin
            if (ax_ff == 2'd2) begin
               state_in = S_SUM;
            end
         end
         S_SUM: state_in = S_ROOT;
         S_ROOT: begin
            if (rcnt_ff == ROOT_CNT_W'(ROOT_ITERS - 1)) begin
               state_in = S_CORD;
            end
         end
         S_CORD: begin
            if (ccnt_ff == CNT_W'(CORDIC_STEPS - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: state_in = S_OUT;
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         x_gain_ff     <= X_GAIN_RST;
         y_gain_ff     <= Y_GAIN_RST;
         z_gain_ff     <= Z_GAIN_RST;
         scl_x_ff      <= '0;
         scl_y_ff      <= '0;
         scl_z_ff      <= '0;
         roll_base_ff  <= '0;
         pitch_base_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         // gain register writes
         if (csr_valid) begin
            case (csr_index)
               CSR_X_GAIN: x_gain_ff <= csr_wdata;
               CSR_Y_GAIN: y_gain_ff <= csr_wdata;
               CSR_Z_GAIN: z_gain_ff <= csr_wdata;
               default: ;
            endcase
         end
         // scaled sample capture
         if (state_ff == S_MUL) begin
            case (ax_ff)
               2'd0:    scl_x_ff <= mul_full[SCL_W-1:0];
               2'd1:    scl_y_ff <= mul_full[SCL_W-1:0];
               default: scl_z_ff <= mul_full[SCL_W-1:0];
            endcase
         end
         // base load on pop
         if (q_pop && (q_item.action == ACT_LOAD)) begin
            roll_base_ff  <= sat_ang((ANG_W+1)'(q_item.roll_load));
            pitch_base_ff <= sat_ang((ANG_W+1)'(q_item.pitch_load));
         end
         // result beat and zero capture
         if ((state_ff == S_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
            if (item_ff.action == ACT_ZERO) begin
               roll_base_ff  <= ang_r_ff;
               pitch_base_ff <= ang_p_ff;
            end
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            item_ff <= q_item;
            ax_ff   <= 2'd0;
         end
         S_MUL: ax_ff <= ax_ff + 2'd1;
         S_PREP: begin
            if ((scl_x_ff == '0) && (scl_y_ff == '0) && (scl_z_ff == '0)) begin
               mx_ff <= '0;
               my_ff <= '0;
               mz_ff <= '0;
            end else begin
               mx_ff <= mag_x;
               my_ff <= mag_y;
               mz_ff <= mag_z;
            end
         end
         S_NORM: begin
            ax_ff <= 2'd0;
            if (|mag_or[SCL_W-1:NORM_BITS]) begin
               mx_ff <= mx_ff >> 1;
               my_ff <= my_ff >> 1;
               mz_ff <= mz_ff >> 1;
            end else if (!mag_or[NORM_BITS-1]) begin
               mx_ff <= mx_ff << 1;
               my_ff <= my_ff << 1;
               mz_ff <= mz_ff << 1;
            end
         end
         S_SQR: begin
            ax_ff <= ax_ff + 2'd1;
            case (ax_ff)
               2'd0:    sq_x_ff <= sq_full;
               2'd1:    sq_y_ff <= sq_full;
               default: sq_z_ff <= sq_full;
            endcase
         end
         S_SUM: begin
            rt_p_ff.n <= RT_W'(sq_y_ff) + RT_W'(sq_z_ff);
            rt_r_ff.n <= RT_W'(sq_x_ff) + RT_W'(sq_z_ff);
            rt_p_ff.r <= '0;
            rt_r_ff.r <= '0;
            bit_ff    <= RT_W'(1) << ROOT_TOP;
            rcnt_ff   <= '0;
         end
         S_ROOT: begin
            rt_p_ff <= rt_p_in;
            rt_r_ff <= rt_r_in;
            bit_ff  <= bit_ff >> 2;
            rcnt_ff <= rcnt_ff + ROOT_CNT_W'(1);
            // last digit: start both cordic lanes
            cd_p_ff.x <= $signed(CX_W'(rt_p_in.r));
            cd_p_ff.y <= $signed(CX_W'(mx_ff[NORM_BITS-1:0]));
            cd_p_ff.z <= '0;
            cd_r_ff.x <= $signed(CX_W'(rt_r_in.r));
            cd_r_ff.y <= $signed(CX_W'(my_ff[NORM_BITS-1:0]));
            cd_r_ff.z <= '0;
            ccnt_ff   <= '0;
         end
         S_CORD: begin
            cd_p_ff <= cd_p_in;
            cd_r_ff <= cd_r_in;
            ccnt_ff <= ccnt_ff + CNT_W'(1);
         end
         S_FIN: begin
            ang_p_ff <= fin_angle(mx_ff[NORM_BITS-1:0] != '0, scl_x_ff[SCL_W-1], cd_p_ff.z);
            ang_r_ff <= fin_angle(my_ff[NORM_BITS-1:0] != '0, scl_y_ff[SCL_W-1], cd_r_ff.z);
         end
         S_OUT: begin
            if (out_free) begin
               if (item_ff.action == ACT_ZERO) begin
                  rsp_roll_ff  <= ang_r_ff;
                  rsp_pitch_ff <= ang_p_ff;
               end else begin
                  rsp_roll_ff  <= sat_ang(diff_r);
                  rsp_pitch_ff <= sat_ang(diff_p);
               end
            end
         end
         default: ;
      endcase
   end

endmodule

/* rtl/core/atrp_checker.sv */
// port-level checks of the tilt block, bound to the top level
// depends on assert_macros.svh and atrp_pkg
`include "assert_macros.svh"

module atrp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [atrp_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import atrp_pkg::*;

   logic [2:0] pend_ff, pend_in;
   logic       in_beat, out_beat;

   assign in_beat  = req_tvalid && req_tready;
   assign out_beat = rsp_tvalid && rsp_tready;

   // items taken but not yet answered
   always_comb begin
      pend_in = pend_ff + {2'b00, in_beat} - {2'b00, out_beat};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `ATRP_ASSERT_NXT(a_rst_idle, clock, 1'b0, reset, !rsp_tvalid)
   `ATRP_ASSERT_IMP(a_no_orphan, clock, reset, rsp_tvalid, pend_ff != 3'd0)
   `ATRP_ASSERT_IMP(a_full_stall, clock, reset, pend_ff == 3'd4, !req_tready)
   `ATRP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind accel_tilt_roll_pitch atrp_checker u_atrp_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// self-checking bench for accel_tilt_roll_pitch: random and directed beats,
// an in-bench roll/pitch predictor and random idling on both streams
// depends on atrp_pkg and the accel_tilt_roll_pitch rtl
module testbench;
   import atrp_pkg::*;

   localparam int STEPS      = CORDIC_STEPS_DEF;
   localparam int WDOG_LIMIT = 20000;
   localparam int DRAIN_WAIT = 200;

   typedef struct {
      logic signed [ANG_W-1:0] roll;
      logic signed [ANG_W-1:0] pitch;
   } angles_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = ACT_NONE;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = CSR_X_GAIN;
   logic [GAIN_W-1:0] csr_wdata = '0;

   accel_tilt_roll_pitch i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of gains, kept vector and bases
   longint unsigned gain_x = X_GAIN_RST, gain_y = Y_GAIN_RST, gain_z = Z_GAIN_RST;
   longint kept_x = 0, kept_y = 0, kept_z = 0;
   longint base_roll = 0, base_pitch = 0;

   const longint arc_q16[24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0};

   item_type   pending_q[$];
   angles_type angles_due[$];
   int errors = 0;
   bit quiet = 1'b0;
   int hold_off = 0;
   int idle_cycles = 0;

   function automatic longint clamp_deg(longint v);
      if (v > 46080) return 46080;
      if (v < -46080) return -46080;
      return v;
   endfunction

   function automatic longint unsigned int_root(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // vectoring arc tangent of two magnitudes, result in 1/256 degree
   function automatic longint arc_deg(longint unsigned a, longint unsigned b);
      longint x, y, z, dx, dy;
      x = longint'(b);
      y = longint'(a);
      z = 0;
      if (a == 0) return 0;
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += arc_q16[i];
         end else begin
            x -= dx; y += dy; z -= arc_q16[i];
         end
      end
      if (z < 0) z = 0;
      if (z > 5898240) z = 5898240;
      return (z + 128) >>> 8;
   endfunction

   function automatic void tilt_of_kept(output longint roll, output longint pitch);
      longint unsigned mx, my, mz, m, t;
      int bl;
      longint p, r;
      mx = kept_x < 0 ? -kept_x : kept_x;
      my = kept_y < 0 ? -kept_y : kept_y;
      mz = kept_z < 0 ? -kept_z : kept_z;
      m = mx;
      bl = 0;
      if (my > m) m = my;
      if (mz > m) m = mz;
      if (m == 0) begin
         roll = 0;
         pitch = 0;
         return;
      end
      for (t = m; t != 0; t >>= 1) bl++;
      if (bl > 30) begin
         mx >>= bl - 30; my >>= bl - 30; mz >>= bl - 30;
      end else begin
         mx <<= 30 - bl; my <<= 30 - bl; mz <<= 30 - bl;
      end
      p = arc_deg(mx, int_root(my * my + mz * mz));
      r = arc_deg(my, int_root(mx * mx + mz * mz));
      pitch = kept_x < 0 ? -p : p;
      roll = kept_y < 0 ? -r : r;
   endfunction

   // apply one accepted beat to the predictor and queue its angles
   function automatic void predict_tilt(item_type it);
      longint roll, pitch;
      angles_type res;
      if (it.action == ACT_MEASURE) begin
         kept_x = longint'($signed(it.x_sample)) * longint'(gain_x);
         kept_y = longint'($signed(it.y_sample)) * longint'(gain_y);
         kept_z = longint'($signed(it.z_sample)) * longint'(gain_z);
      end else if (it.action == ACT_LOAD) begin
         base_roll = clamp_deg(longint'(it.roll_load));
         base_pitch = clamp_deg(longint'(it.pitch_load));
      end
      tilt_of_kept(roll, pitch);
      if (it.action == ACT_ZERO) begin
         base_roll = roll;
         base_pitch = pitch;
      end else begin
         roll = clamp_deg(roll - base_roll);
         pitch = clamp_deg(pitch - base_pitch);
      end
      res.roll = roll[ANG_W-1:0];
      res.pitch = pitch[ANG_W-1:0];
      angles_due.push_back(res);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_tilt(pending_q.pop_front());
         end
         if (!(req_tvalid && !req_tready)) begin
            if (pending_q.size() > 0 && (quiet || $urandom_range(99) >= 16)) begin
               req_tvalid <= 1'b1;
               req_tuser <= pending_q[0].action;
               req_tdata <= {6'b0, pending_q[0].pitch_load, pending_q[0].roll_load,
                             pending_q[0].z_sample, pending_q[0].y_sample,
                             pending_q[0].x_sample};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor and backpressure
   always @(posedge clock) begin
      angles_type want;
      logic signed [ANG_W-1:0] got_roll, got_pitch;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_roll = rsp_tdata[ANG_W-1:0];
         got_pitch = rsp_tdata[2*ANG_W-1:ANG_W];
         if (angles_due.size() == 0) begin
            $error("response beat with nothing expected");
            errors++;
         end else begin
            want = angles_due.pop_front();
            if (got_roll !== want.roll) begin
               $error("roll_deg expected %0d actual %0d", want.roll, got_roll);
               errors++;
            end
            if (got_pitch !== want.pitch) begin
               $error("pitch_deg expected %0d actual %0d", want.pitch, got_pitch);
               errors++;
            end
         end
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || $urandom_range(99) >= 16;
      end
   end

   // watchdog on stalled traffic
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || (pending_q.size() == 0 && angles_due.size() == 0)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_gain(logic [1:0] idx, logic [GAIN_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      case (idx)
         CSR_X_GAIN: gain_x = val;
         CSR_Y_GAIN: gain_y = val;
         default:    gain_z = val;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      wait (pending_q.size() == 0 && angles_due.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic logic [IN_W-1:0] rand_sample();
      case ($urandom_range(5))
         0:       return $urandom_range(1) ? 16'h7fff : 16'h8000;
         1:       return 16'(int'($urandom_range(16)) - 8);
         2:       return '0;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic item_type rand_item();
      item_type it;
      int pick;
      pick = $urandom_range(99);
      it.action = pick < 65 ? ACT_MEASURE : pick < 78 ? ACT_ZERO :
                  pick < 94 ? ACT_LOAD : ACT_NONE;
      it.x_sample = rand_sample();
      it.y_sample = rand_sample();
      it.z_sample = rand_sample();
      if ($urandom_range(4) == 0) begin
         it.roll_load = 17'($urandom);
         it.pitch_load = 17'($urandom);
      end else begin
         it.roll_load = 17'(int'($urandom_range(92160)) - 46080);
         it.pitch_load = 17'(int'($urandom_range(92160)) - 46080);
      end
      return it;
   endfunction

   function automatic item_type mk(action_type a, int x, int y, int z, int r, int p);
      item_type it;
      it.action = a;
      it.x_sample = 16'(x);
      it.y_sample = 16'(y);
      it.z_sample = 16'(z);
      it.roll_load = 17'(r);
      it.pitch_load = 17'(p);
      return it;
   endfunction

   task automatic push_random(int n);
      repeat (n) pending_q.push_back(rand_item());
   endtask

   // stimulus
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every action, zero vector, base saturation
      pending_q.push_back(mk(ACT_NONE, 0, 0, 0, 0, 0));
      pending_q.push_back(mk(ACT_ZERO, 0, 0, 0, 0, 0));
      pending_q.push_back(mk(ACT_MEASURE, 0, 0, 0, 0, 0));
      pending_q.push_back(mk(ACT_MEASURE, 32767, 0, 0, 0, 0));
      pending_q.push_back(mk(ACT_MEASURE, -32768, 0, 0, 0, 0));
      pending_q.push_back(mk(ACT_MEASURE, 0, 32767, 0, 0, 0));
      pending_q.push_back(mk(ACT_MEASURE, 0, -32768, 0, 0, 0));
      pending_q.push_back(mk(ACT_MEASURE, 0, 0, -32768, 0, 0));
      pending_q.push_back(mk(ACT_MEASURE, 32767, 32767, 32767, 0, 0));
      pending_q.push_back(mk(ACT_MEASURE, -32768, -32768, -32768, 0, 0));
      pending_q.push_back(mk(ACT_MEASURE, 1, -1, 256, 0, 0));
      pending_q.push_back(mk(ACT_ZERO, 0, 0, 0, 0, 0));
      pending_q.push_back(mk(ACT_MEASURE, -32768, 32767, 0, 0, 0));
      pending_q.push_back(mk(ACT_LOAD, 0, 0, 0, 46080, -46080));
      pending_q.push_back(mk(ACT_LOAD, 0, 0, 0, 65535, -65536));
      pending_q.push_back(mk(ACT_MEASURE, 32767, -32768, 5, 0, 0));
      pending_q.push_back(mk(ACT_LOAD, 0, 0, 0, -46080, 46080));
      pending_q.push_back(mk(ACT_MEASURE, -32768, 32767, 5, 0, 0));
      pending_q.push_back(mk(ACT_NONE, 123, -45, 7, 1000, -1000));
      pending_q.push_back(mk(ACT_LOAD, 0, 0, 0, 0, 0));
      push_random(155);
      drain();

      // full-scale gains, no idling at all
      quiet = 1'b1;
      write_gain(CSR_X_GAIN, 24'hffffff);
      write_gain(CSR_Y_GAIN, 24'hffffff);
      write_gain(CSR_Z_GAIN, 24'hffffff);
      push_random(125);
      drain();
      quiet = 1'b0;

      // zero gains; long receiver hold-off while requests keep coming
      write_gain(CSR_X_GAIN, 24'd0);
      write_gain(CSR_Y_GAIN, 24'd0);
      write_gain(CSR_Z_GAIN, 24'd0);
      hold_off = 400;
      push_random(125);
      drain();

      // random gains, sender pauses mid-phase until all results are back
      write_gain(CSR_X_GAIN, 24'($urandom));
      write_gain(CSR_Y_GAIN, 24'($urandom));
      write_gain(CSR_Z_GAIN, 24'($urandom));
      push_random(60);
      wait (pending_q.size() == 0 && angles_due.size() == 0);
      push_random(65);
      drain();

      // one zero axis gain and unit gains
      write_gain(CSR_X_GAIN, 24'd1);
      write_gain(CSR_Y_GAIN, 24'($urandom));
      write_gain(CSR_Z_GAIN, 24'd0);
      push_random(100);
      drain();
      write_gain(CSR_X_GAIN, 24'h800000);
      write_gain(CSR_Y_GAIN, 24'd1);
      write_gain(CSR_Z_GAIN, 24'h7fffff);
      push_random(100);
      drain();

      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
